/* rtl/stq_pkg.sv */
// Shared types and constants for the sorted timer queue.
// Used by the timer queue top level and its port checker; depends on nothing.
`timescale 1ns / 1ps

package stq_pkg;

  // Default number of timer slots.
  localparam int unsigned TIMER_SLOTS_DEF = 16;

  // Field widths of a request and a result.
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ID_W    = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned COUNT_W = 5;

  // Highest pending count that the four-bit timer ids allow.
  localparam int unsigned COUNT_MAX = 2 ** ID_W;

  // Request tdata layout, lowest bit first.
  localparam int unsigned IN_ID_LSB   = 0;
  localparam int unsigned IN_IVAL_LSB = IN_ID_LSB + ID_W;
  localparam int unsigned IN_PER_LSB  = IN_IVAL_LSB + TIME_W;
  localparam int unsigned IN_NOW_LSB  = IN_PER_LSB + 1;
  localparam int unsigned IN_DATA_W   = 72;

  // Result tdata layout, lowest bit first.
  localparam int unsigned OUT_FID_LSB = 0;
  localparam int unsigned OUT_CNT_LSB = OUT_FID_LSB + ID_W;
  localparam int unsigned OUT_DATA_W  = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_START = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_REM,
    S_REARM,
    S_INS,
    S_OUT
  } state_e;

endpackage

/* rtl/stq_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module stq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/sorted_timer_queue.sv */
// Sorted timer queue top level: command sequencer, active flags and result register.
// Depends on stq_pkg and on stq_ram for the order list and the slot store.
`timescale 1ns / 1ps

// A request on the slave stream carries a command in tuser (start, stop or tick) and the
// timer id, interval, periodic flag and current time in tdata. Every request produces
// exactly one result on the master stream: a fired flag in tuser, the fired timer id and
// the number of queued timers in tdata.
// The queue is an order list in RAM whose entries hold a deadline and a timer id, sorted
// by deadline. Removal walks it from the front and shifts the tail down by one; insertion
// walks it from the back, shifting entries up until an earlier or equal deadline is seen.
// Each walk is paced by the single read port of the order RAM and its registered read. One
// request is processed at a time; s_axis_tready is high only while the sequencer is idle.
// Results leave through an output register, so a new request is taken while a result
// still waits; a request finishing while the register is still full holds there until
// m_axis_tready frees it. Reset clears the queue count, all active flags and the result
// valid; the RAM contents need no clearing because only queued entries are read.

module sorted_timer_queue #(
  parameter int unsigned TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: timer_id[3:0], interval[35:4], periodic[36], current_time[68:37], zero fill
  input  logic [stq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [stq_pkg::MODE_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: fired_timer[3:0], pending_count[8:4], zero fill
  output logic [stq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // tuser: fired[0]
  output logic [0:0]                     m_axis_tuser
);

  import stq_pkg::*;

  localparam int unsigned IW = $clog2(TIMER_SLOTS);      // slot index width
  localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);  // queue count width
  localparam int unsigned OW = TIME_W + IW;              // order entry: {deadline, id}
  localparam int unsigned SW = TIME_W + 1;               // slot entry: {periodic, interval}

  // Request fields.
  logic [ID_W-1:0]   in_id;
  logic [TIME_W-1:0] in_ival;
  logic              in_per;
  logic [TIME_W-1:0] in_now;
  mode_e             in_mode;
  logic [IW+ID_W-1:0] in_id_wide;
  logic [IW-1:0]     in_slot;
  logic              in_id_ok;
  logic              accept;

  assign in_id      = s_axis_tdata[IN_ID_LSB +: ID_W];
  assign in_ival    = s_axis_tdata[IN_IVAL_LSB +: TIME_W];
  assign in_per     = s_axis_tdata[IN_PER_LSB];
  assign in_now     = s_axis_tdata[IN_NOW_LSB +: TIME_W];
  assign in_mode    = mode_e'(s_axis_tuser);
  assign in_id_wide = {IW'(0), in_id};
  assign in_slot    = in_id_wide[IW-1:0];
  assign in_id_ok   = in_id_wide < (IW + ID_W)'(TIMER_SLOTS);
  assign accept     = s_axis_tvalid && s_axis_tready;

  // Sequencer state.
  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [TIMER_SLOTS-1:0] active_q, active_d;
  logic [CW-1:0]      ptr_q, ptr_d;
  logic [IW-1:0]      tag_q, tag_d;
  logic               pend_q, pend_d;
  logic               found_q, found_d;
  mode_e              mode_q, mode_d;
  logic [IW-1:0]      rid_q, rid_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TIME_W-1:0]  dl_q, dl_d;
  logic               fired_q, fired_d;
  logic [IW-1:0]      fid_q, fid_d;

  // Result register.
  logic               out_valid_q, out_valid_d;
  logic               out_fired_q, out_fired_d;
  logic [ID_W-1:0]    out_fid_q, out_fid_d;
  logic [COUNT_W-1:0] out_cnt_q, out_cnt_d;
  logic [IW+ID_W-1:0]    fid_wide;
  logic [CW+COUNT_W-1:0] cnt_wide;

  // RAM ports.
  logic          ord_we, ord_re;
  logic [IW-1:0] ord_waddr, ord_raddr;
  logic [OW-1:0] ord_wdata, ord_rdata;
  logic          slot_we, slot_re;
  logic [IW-1:0] slot_waddr, slot_raddr;
  logic [SW-1:0] slot_wdata, slot_rdata;

  logic [TIME_W-1:0] ord_dl;
  logic [IW-1:0]     ord_id;
  logic              slot_per;
  logic [TIME_W-1:0] slot_ival;
  logic [OW-1:0]     new_entry;

  logic head_due;
  logic rem_done;
  logic ins_done;
  logic out_free;

  assign ord_dl    = ord_rdata[OW-1:IW];
  assign ord_id    = ord_rdata[IW-1:0];
  assign slot_per  = slot_rdata[SW-1];
  assign slot_ival = slot_rdata[TIME_W-1:0];
  assign new_entry = {dl_q, rid_q};

  // The head fires when its deadline is not later than the time of the tick.
  assign head_due = ord_dl <= now_q;
  // The removal walk ends once every queued entry has been read and handled.
  assign rem_done = (state_q == S_REM) && !pend_q && (ptr_q == cnt_q);
  // The insertion walk ends at the first entry from the back that is not later than the
  // new deadline, or once the front of the list has been passed.
  assign ins_done = (state_q == S_INS) && (pend_q ? (ord_dl <= dl_q) : (ptr_q == '0));
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == S_IDLE);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_START: begin
              if (!in_id_ok) begin
                state_d = S_OUT;
              end else if (active_q[in_slot]) begin
                state_d = S_REM;
              end else begin
                state_d = S_INS;
              end
            end
            MODE_STOP: begin
              state_d = (in_id_ok && active_q[in_slot]) ? S_REM : S_OUT;
            end
            MODE_TICK: begin
              state_d = (cnt_q != '0) ? S_HEAD_RD : S_OUT;
            end
            default: begin
              state_d = S_OUT;
            end
          endcase
        end
      end
      S_HEAD_RD: begin
        state_d = S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        state_d = head_due ? S_REM : S_OUT;
      end
      S_REM: begin
        if (rem_done) begin
          case (mode_q)
            MODE_START: state_d = S_INS;
            MODE_TICK:  state_d = S_REARM;
            default:    state_d = S_OUT;
          endcase
        end
      end
      S_REARM: begin
        state_d = slot_per ? S_INS : S_OUT;
      end
      S_INS: begin
        if (ins_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath, RAM accesses and result loading.
  always_comb begin
    cnt_d       = cnt_q;
    active_d    = active_q;
    ptr_d       = ptr_q;
    tag_d       = tag_q;
    pend_d      = pend_q;
    found_d     = found_q;
    mode_d      = mode_q;
    rid_d       = rid_q;
    now_d       = now_q;
    dl_d        = dl_q;
    fired_d     = fired_q;
    fid_d       = fid_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_fired_d = out_fired_q;
    out_fid_d   = out_fid_q;
    out_cnt_d   = out_cnt_q;
    ord_we      = 1'b0;
    ord_waddr   = '0;
    ord_wdata   = new_entry;
    ord_re      = 1'b0;
    ord_raddr   = '0;
    slot_we     = 1'b0;
    slot_waddr  = in_slot;
    slot_wdata  = {in_per, in_ival};
    slot_re     = 1'b0;
    slot_raddr  = ord_id;
    fid_wide    = {ID_W'(0), fid_q};
    cnt_wide    = {COUNT_W'(0), cnt_q};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d  = in_mode;
          rid_d   = in_slot;
          now_d   = in_now;
          dl_d    = in_now + in_ival;
          fired_d = 1'b0;
          fid_d   = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
          // A start of an idle timer goes straight to insertion, which walks from the back.
          if (in_mode == MODE_START && in_id_ok && !active_q[in_slot]) begin
            ptr_d = cnt_q;
          end else begin
            ptr_d = '0;
          end
          slot_we = (in_mode == MODE_START) && in_id_ok;
        end
      end
      S_HEAD_RD: begin
        ord_re = 1'b1;
      end
      S_HEAD_CHK: begin
        // Fetch the head's interval now; the RAM output holds it until re-arming.
        slot_re = 1'b1;
        if (head_due) begin
          fired_d = 1'b1;
          fid_d   = ord_id;
          rid_d   = ord_id;
          ptr_d   = '0;
          pend_d  = 1'b0;
          found_d = 1'b0;
        end
      end
      S_REM: begin
        if (pend_q) begin
          if (found_q) begin
            ord_we    = 1'b1;
            ord_waddr = tag_q - IW'(1);
            ord_wdata = ord_rdata;
          end else if (ord_id == rid_q) begin
            found_d = 1'b1;
          end
        end
        if (ptr_q != cnt_q) begin
          ord_re    = 1'b1;
          ord_raddr = ptr_q[IW-1:0];
          tag_d     = ptr_q[IW-1:0];
          ptr_d     = ptr_q + CW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (rem_done) begin
          cnt_d           = cnt_q - CW'(1);
          active_d[rid_q] = 1'b0;
          ptr_d           = cnt_q - CW'(1);
        end
      end
      S_REARM: begin
        dl_d   = now_q + slot_ival;
        ptr_d  = cnt_q;
        pend_d = 1'b0;
      end
      S_INS: begin
        if (pend_q) begin
          ord_we    = 1'b1;
          ord_waddr = tag_q + IW'(1);
          ord_wdata = (ord_dl > dl_q) ? ord_rdata : new_entry;
        end else if (ptr_q == '0) begin
          ord_we    = 1'b1;
          ord_waddr = '0;
        end
        if (!ins_done && ptr_q != '0) begin
          ord_re    = 1'b1;
          ord_raddr = IW'(ptr_q - CW'(1));
          tag_d     = IW'(ptr_q - CW'(1));
          ptr_d     = ptr_q - CW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (ins_done) begin
          cnt_d           = cnt_q + CW'(1);
          active_d[rid_q] = 1'b1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_fired_d = fired_q;
          out_fid_d   = fid_wide[ID_W-1:0];
          out_cnt_d   = cnt_wide[COUNT_W-1:0];
        end
      end
      default: begin
        pend_d = 1'b0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      active_q    <= '0;
      pend_q      <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      active_q    <= active_d;
      pend_q      <= pend_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    tag_q       <= tag_d;
    mode_q      <= mode_d;
    rid_q       <= rid_d;
    now_q       <= now_d;
    dl_q        <= dl_d;
    fired_q     <= fired_d;
    fid_q       <= fid_d;
    out_fired_q <= out_fired_d;
    out_fid_q   <= out_fid_d;
    out_cnt_q   <= out_cnt_d;
  end

  // Queued timers in deadline order, each entry {deadline, id}.
  stq_ram #(
    .WIDTH (OW),
    .DEPTH (TIMER_SLOTS)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  // Per-slot {periodic, interval}, written on start and read when a tick checks the head.
  stq_ram #(
    .WIDTH (SW),
    .DEPTH (TIMER_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_fired_q;
  assign m_axis_tdata  = {(OUT_DATA_W - ID_W - COUNT_W)'(0), out_cnt_q, out_fid_q};

endmodule

/* rtl/stq_checker.sv */
// Port-level checker for the sorted timer queue, bound to its top level.
// Depends on stq_pkg and on the ports of sorted_timer_queue.
`timescale 1ns / 1ps

module stq_port_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [stq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [stq_pkg::MODE_W-1:0]     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [stq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);

  import stq_pkg::*;

  // A stalled result keeps its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A result that did not fire names timer zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[OUT_FID_LSB +: ID_W] == '0)
    else $error("fired_timer set without fired");

  // The queue never holds more timers than there are ids.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_CNT_LSB +: COUNT_W] <= COUNT_W'(COUNT_MAX))
    else $error("pending_count out of range");

  // Requests are processed one at a time: ready drops right after a request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

endmodule

bind sorted_timer_queue stq_port_checker u_stq_checker (.*);
